FILE: rtl/cfa_pkg.sv
// Shared constants and the byte-wide CRC-32 step for the framed archive checker.
package cfa_pkg;

	localparam int unsigned CountW = 25;
	localparam logic [CountW-1:0] CountMax = {CountW{1'b1}};
	localparam logic [CountW-1:0] MinFrameBytes = 25'd42;
	localparam logic [CountW-1:0] HeaderBytes = 25'd16;
	localparam logic [CountW-1:0] MagicEnd = 25'd8;
	localparam logic [CountW-1:0] LengthEnd = 25'd12;
	localparam logic [CountW-1:0] FirstPayload = 25'd16;
	localparam logic [CountW-1:0] SecondPayload = 25'd17;
	localparam logic [7:0] PayloadTag = 8'd1;

	localparam logic [31:0] CrcPoly = 32'hEDB88320;
	localparam logic [31:0] CrcInit = 32'hFFFFFFFF;

	localparam logic [63:0] MagicReset = 64'h4C454D4F4E535631;
	localparam logic [23:0] MaxPayloadReset = 24'd8388608;

	// configuration register indexes
	localparam logic [7:0] RegMagic = 8'd0;
	localparam logic [7:0] RegMaxPayload = 8'd1;

	// reflected CRC-32, one byte, eight shift steps unrolled
	function automatic logic [31:0] crc_byte(input logic [31:0] crc, input logic [7:0] b);
		logic [31:0] c;
		c = crc ^ {24'd0, b};
		for (int k = 0; k < 8; k++) begin
			c = (c >> 1) ^ (c[0] ? CrcPoly : 32'd0);
		end
		return c;
	endfunction

endpackage

FILE: rtl/crc32_framed_archive_check.sv
// Top level of the framed archive checker: input stage, status register, config regs.
//
// Input channel: one archive byte per beat (data_byte, last_byte) on in_valid/in_ready.
// Output channel: one status beat per archive (0 valid, 1 invalid) on out_valid/out_ready,
// issued only for the beat that carries last_byte.
// Config channel: cfg_index 0 writes the 64-bit magic (first byte in bits 63..56),
// index 1 writes the 24-bit payload limit from cfg_data[23:0]; other indexes are
// ignored. cfg_ready is always high; write only while no archive is in flight.
// Order: a byte enters the input register on acceptance and is folded into the frame
// state when that register fires; a final byte's status is registered in the same edge,
// so out_valid is driven by the status register, behind the input register.
// Throughput: one byte per cycle through the byte-wide CRC update, unless the output stalls.
// When the receiver stalls, the status waits in the output register; the input
// register still holds one more byte and further non-final bytes keep flowing until a
// second final byte meets the full output register, then in_ready drops.
// Reset clears the frame state, the stages and loads the default magic and limit.
module crc32_framed_archive_check
	import cfa_pkg::*;
(
	input  logic        clk,
	input  logic        arst_n,
	input  logic        in_valid,
	output logic        in_ready,
	input  logic [7:0]  data_byte,
	input  logic        last_byte,
	output logic        out_valid,
	input  logic        out_ready,
	output logic        status,
	input  logic        cfg_valid,
	output logic        cfg_ready,
	input  logic [7:0]  cfg_index,
	input  logic [63:0] cfg_data
);

	logic        valid_s1;
	logic [7:0]  byte_s1;
	logic        last_s1;
	logic        fire_s1;
	logic        status_next;
	logic [63:0] magic_q;
	logic [23:0] max_payload_q;
	logic        out_valid_q;
	logic        status_q;

	// stage fires unless a final byte finds the status register occupied and not being read
	assign fire_s1  = valid_s1 && (!last_s1 || !out_valid_q || out_ready);
	assign in_ready = !valid_s1 || fire_s1;
	assign cfg_ready = 1'b1;

	// input register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (in_ready) begin
			valid_s1 <= in_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (in_valid && in_ready) begin
			byte_s1 <= data_byte;
			last_s1 <= last_byte;
		end
	end

	// configuration registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			magic_q       <= MagicReset;
			max_payload_q <= MaxPayloadReset;
		end else if (cfg_valid && cfg_ready) begin
			if (cfg_index == RegMagic) magic_q <= cfg_data;
			if (cfg_index == RegMaxPayload) max_payload_q <= cfg_data[23:0];
		end
	end

	cfa_frame_tracker u_tracker (
		.clk               (clk),
		.arst_n            (arst_n),
		.step              (fire_s1),
		.data_byte         (byte_s1),
		.last_byte         (last_s1),
		.magic_word        (magic_q),
		.max_payload_bytes (max_payload_q),
		.status            (status_next)
	);

	// status register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (fire_s1 && last_s1) begin
			out_valid_q <= 1'b1;
		end else if (out_ready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (fire_s1 && last_s1) status_q <= status_next;
	end

	assign out_valid = out_valid_q;
	assign status    = status_q;

endmodule

FILE: rtl/cfa_frame_tracker.sv
// Per-archive state: magic, header fields, payload CRC and the final verdict.
module cfa_frame_tracker
	import cfa_pkg::*;
(
	input  logic        clk,
	input  logic        arst_n,
	input  logic        step,
	input  logic [7:0]  data_byte,
	input  logic        last_byte,
	input  logic [63:0] magic_word,
	input  logic [23:0] max_payload_bytes,
	output logic        status
);

	logic [CountW-1:0] count_q, count_d;
	logic              magic_ok_q, magic_ok_d;
	logic [31:0]       length_q, length_d;
	logic [31:0]       crc_field_q, crc_field_d;
	logic [31:0]       crc_q, crc_d;
	logic              format_ok_q, format_ok_d;

	logic [5:0]        magic_lane;
	logic [4:0]        field_lane;
	logic [CountW-1:0] payload_len;
	logic              frame_ok;

	assign magic_lane = {3'd7 - count_q[2:0], 3'b000};
	assign field_lane = {count_q[1:0], 3'b000};

	// next state for this byte
	always_comb begin
		magic_ok_d  = magic_ok_q;
		length_d    = length_q;
		crc_field_d = crc_field_q;
		crc_d       = crc_q;
		format_ok_d = format_ok_q;
		priority if (count_q < MagicEnd) begin
			if (magic_word[magic_lane +: 8] != data_byte) magic_ok_d = 1'b0;
		end else if (count_q < LengthEnd) begin
			length_d[field_lane +: 8] = length_q[field_lane +: 8] | data_byte;
		end else if (count_q < HeaderBytes) begin
			crc_field_d[field_lane +: 8] = crc_field_q[field_lane +: 8] | data_byte;
		end else begin
			crc_d = crc_byte(crc_q, data_byte);
			if ((count_q == FirstPayload || count_q == SecondPayload) &&
			    data_byte != PayloadTag) format_ok_d = 1'b0;
		end
		count_d = (count_q < CountMax) ? count_q + 1'b1 : count_q;
	end

	// verdict on the updated state
	assign payload_len = count_d - HeaderBytes;
	assign frame_ok = (count_d >= MinFrameBytes) &&
	                  (payload_len <= {1'b0, max_payload_bytes}) &&
	                  magic_ok_d && format_ok_d &&
	                  (length_d == {7'd0, payload_len}) &&
	                  (crc_field_d == ~crc_d);
	assign status = ~frame_ok;

	// state registers, cleared after the final byte
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			count_q     <= '0;
			magic_ok_q  <= 1'b1;
			length_q    <= '0;
			crc_field_q <= '0;
			crc_q       <= CrcInit;
			format_ok_q <= 1'b1;
		end else if (step) begin
			if (last_byte) begin
				count_q     <= '0;
				magic_ok_q  <= 1'b1;
				length_q    <= '0;
				crc_field_q <= '0;
				crc_q       <= CrcInit;
				format_ok_q <= 1'b1;
			end else begin
				count_q     <= count_d;
				magic_ok_q  <= magic_ok_d;
				length_q    <= length_d;
				crc_field_q <= crc_field_d;
				crc_q       <= crc_d;
				format_ok_q <= format_ok_d;
			end
		end
	end

endmodule
